>>> hdl/scc_pkg.sv
// Shared types, constants and helpers for the sector cache tag and policy controller.
// No dependencies; every other file of the block imports this package.
package scc_pkg;

  localparam int NUM_SLOTS   = 64;
  localparam int SECTOR_BITS = 32;
  localparam int SLOT_W      = $clog2(NUM_SLOTS);
  localparam int CMD_W       = 2;

  typedef logic [SLOT_W-1:0]      slot_t;
  typedef logic [SECTOR_BITS-1:0] sector_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_FLUSH = 2'd2
  } scc_cmd_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOKUP,
    S_HIT,
    S_SWEEP,
    S_MISS,
    S_FL_FIND,
    S_FL_NONE,
    S_FL_CHECK,
    S_FL_OUT
  } scc_state_e;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_TOP,
    IDX_INC,
    IDX_DEC
  } scc_idx_op_e;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_HIT,
    EMIT_MISS,
    EMIT_FLUSH
  } scc_emit_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic        load;        // capture the incoming request
    scc_idx_op_e idx_op;      // scan / flush index update
    logic        scan;        // present idx_q to the compare stage next cycle
    logic        rd_en;       // read the tag store
    logic        rd_hand;     // tag read address is the clock hand, else the index
    logic        sel_load;    // remember the slot that matched
    logic        lastd_load;  // remember the highest dirty slot
    logic        sweep_step;  // clear the reference bit under the hand and advance
    logic        emit;        // load the result register and commit state
    scc_emit_e   kind;
  } scc_ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic match;
    logic scan_end;
    logic sweep_found;
    logic fl_dirty;
    logic idx_zero;
    logic idx_lastd;
    logic out_free;
  } scc_stat_t;

  function automatic slot_t slot_inc(slot_t s);
    slot_inc = (s == SLOT_W'(NUM_SLOTS - 1)) ? '0 : s + 1'b1;
  endfunction

endpackage

>>> hdl/scc_if.sv
// Handshake channel interfaces for requests and results of the sector cache controller.
// Depends on scc_pkg for payload types.
interface scc_req_if;
  import scc_pkg::*;
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  sector_t          sector;

  modport source (output valid, command, sector, input ready);
  modport sink   (input valid, command, sector, output ready);
endinterface

interface scc_rsp_if;
  import scc_pkg::*;
  logic    valid;
  logic    ready;
  logic    hit;
  slot_t   slot;
  logic    fill_needed;
  logic    writeback_needed;
  sector_t writeback_sector;
  logic    last;

  modport source (output valid, hit, slot, fill_needed, writeback_needed,
                  writeback_sector, last, input ready);
  modport sink   (input valid, hit, slot, fill_needed, writeback_needed,
                  writeback_sector, last, output ready);
endinterface

>>> hdl/scc_datapath.sv
// Datapath: tag store, valid/dirty/reference bits, clock hand, scan index and result register.
// Depends on scc_pkg; driven by scc_controller through scc_ctrl_t.
module scc_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  scc_pkg::scc_ctrl_t ctrl_i,
  output scc_pkg::scc_stat_t stat_o,
  input  logic [1:0]         req_command_i,
  input  scc_pkg::sector_t   req_sector_i,
  input  logic               rsp_ready_i,
  output logic               rsp_valid_o,
  output logic               rsp_hit_o,
  output scc_pkg::slot_t     rsp_slot_o,
  output logic               rsp_fill_needed_o,
  output logic               rsp_writeback_needed_o,
  output scc_pkg::sector_t   rsp_writeback_sector_o,
  output logic               rsp_last_o
);
  import scc_pkg::*;

  sector_t tag_mem [NUM_SLOTS];
  sector_t tag_rd_q;
  slot_t   rd_addr;
  logic    mem_we;

  logic [NUM_SLOTS-1:0] valid_q, dirty_q, ref_q;
  slot_t   hand_q, idx_q, chk_idx_q, sel_q, lastd_q;
  logic    chk_en_q;
  logic    is_write_q;
  sector_t sector_q;

  logic    out_valid_q, out_hit_q, out_fill_q, out_wb_q, out_last_q;
  slot_t   out_slot_q;
  sector_t out_wbs_q;

  logic    res_hit, res_fill, res_wb, res_last;
  slot_t   res_slot;
  sector_t res_wbs;

  assign rd_addr = ctrl_i.rd_hand ? hand_q : idx_q;
  assign mem_we  = ctrl_i.emit && (ctrl_i.kind == EMIT_MISS);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      tag_rd_q <= tag_mem[rd_addr];
    end
    if (mem_we) begin
      tag_mem[hand_q] <= sector_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      is_write_q <= (req_command_i == CMD_WRITE);
      sector_q   <= req_sector_i;
    end
    if (ctrl_i.scan) begin
      chk_idx_q <= idx_q;
    end
    if (ctrl_i.sel_load) begin
      sel_q <= chk_idx_q;
    end
    if (ctrl_i.lastd_load) begin
      lastd_q <= idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      chk_en_q <= 1'b0;
    end else begin
      chk_en_q <= ctrl_i.scan;
      case (ctrl_i.idx_op)
        IDX_ZERO: idx_q <= '0;
        IDX_TOP:  idx_q <= SLOT_W'(NUM_SLOTS - 1);
        IDX_INC:  idx_q <= slot_inc(idx_q);
        IDX_DEC:  idx_q <= idx_q - 1'b1;
        default:  idx_q <= idx_q;
      endcase
    end
  end

  // Replacement state. The hand only moves while sweeping, so a miss commits on it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      dirty_q <= '0;
      ref_q   <= '0;
      hand_q  <= '0;
    end else begin
      if (ctrl_i.sweep_step) begin
        ref_q[hand_q] <= 1'b0;
        hand_q        <= slot_inc(hand_q);
      end
      if (ctrl_i.emit) begin
        case (ctrl_i.kind)
          EMIT_HIT: begin
            ref_q[sel_q] <= 1'b1;
            if (is_write_q) begin
              dirty_q[sel_q] <= 1'b1;
            end
          end
          EMIT_MISS: begin
            valid_q[hand_q] <= 1'b1;
            dirty_q[hand_q] <= is_write_q;
            ref_q[hand_q]   <= 1'b1;
          end
          EMIT_FLUSH: dirty_q[idx_q] <= 1'b0;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    res_hit  = 1'b0;
    res_slot = '0;
    res_fill = 1'b0;
    res_wb   = 1'b0;
    res_wbs  = '0;
    res_last = 1'b1;
    case (ctrl_i.kind)
      EMIT_HIT: begin
        res_hit  = 1'b1;
        res_slot = sel_q;
      end
      EMIT_MISS: begin
        res_slot = hand_q;
        res_fill = 1'b1;
        res_wb   = valid_q[hand_q] & dirty_q[hand_q];
        res_wbs  = res_wb ? tag_rd_q : '0;
      end
      EMIT_FLUSH: begin
        res_slot = idx_q;
        res_wb   = 1'b1;
        res_wbs  = tag_rd_q;
        res_last = (idx_q == lastd_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.emit) begin
      out_hit_q  <= res_hit;
      out_slot_q <= res_slot;
      out_fill_q <= res_fill;
      out_wb_q   <= res_wb;
      out_wbs_q  <= res_wbs;
      out_last_q <= res_last;
    end
  end

  assign rsp_valid_o            = out_valid_q;
  assign rsp_hit_o              = out_hit_q;
  assign rsp_slot_o             = out_slot_q;
  assign rsp_fill_needed_o      = out_fill_q;
  assign rsp_writeback_needed_o = out_wb_q;
  assign rsp_writeback_sector_o = out_wbs_q;
  assign rsp_last_o             = out_last_q;

  // The compare stage sees the tag read issued in the previous cycle for chk_idx_q.
  assign stat_o.match       = chk_en_q & valid_q[chk_idx_q] & (tag_rd_q == sector_q);
  assign stat_o.scan_end    = chk_en_q & (chk_idx_q == SLOT_W'(NUM_SLOTS - 1));
  assign stat_o.sweep_found = ~valid_q[hand_q] | ~ref_q[hand_q];
  assign stat_o.fl_dirty    = valid_q[idx_q] & dirty_q[idx_q];
  assign stat_o.idx_zero    = (idx_q == '0);
  assign stat_o.idx_lastd   = (idx_q == lastd_q);
  assign stat_o.out_free    = ~out_valid_q | rsp_ready_i;

`ifndef SYNTHESIS
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.emit |-> stat_o.out_free)
    else $error("result loaded while the previous one is still held");

  a_hit_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_hit_q |-> !out_fill_q && !out_wb_q)
    else $error("hit result requests a fill or writeback");

  a_miss_installs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.emit && (ctrl_i.kind == EMIT_MISS)
      |=> valid_q[$past(hand_q)] && ref_q[$past(hand_q)])
    else $error("miss did not install the victim slot");

  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.emit && (ctrl_i.kind == EMIT_FLUSH) |=> !dirty_q[$past(idx_q)])
    else $error("flushed slot still dirty");
`endif

endmodule

>>> hdl/scc_controller.sv
// Controller state machine: sequences lookup, clock sweep and flush over the datapath.
// Depends on scc_pkg; talks to scc_datapath only through scc_ctrl_t and scc_stat_t.
module scc_controller (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  input  logic [1:0]         req_command_i,
  output logic               req_ready_o,
  input  scc_pkg::scc_stat_t stat_i,
  output scc_pkg::scc_ctrl_t ctrl_o
);
  import scc_pkg::*;

  scc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    ctrl_o      = '0;
    ctrl_o.kind = EMIT_NONE;
    req_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          ctrl_o.load = 1'b1;
          case (req_command_i)
            CMD_READ, CMD_WRITE: begin
              ctrl_o.idx_op = IDX_ZERO;
              state_d       = S_LOOKUP;
            end
            CMD_FLUSH: begin
              ctrl_o.idx_op = IDX_TOP;
              state_d       = S_FL_FIND;
            end
            default: ;
          endcase
        end
      end
      // One tag read per cycle, compared in the next cycle.
      S_LOOKUP: begin
        ctrl_o.scan   = 1'b1;
        ctrl_o.rd_en  = 1'b1;
        ctrl_o.idx_op = IDX_INC;
        if (stat_i.match) begin
          ctrl_o.sel_load = 1'b1;
          state_d         = S_HIT;
        end else if (stat_i.scan_end) begin
          state_d = S_SWEEP;
        end
      end
      S_HIT: begin
        if (stat_i.out_free) begin
          ctrl_o.emit = 1'b1;
          ctrl_o.kind = EMIT_HIT;
          state_d     = S_IDLE;
        end
      end
      // The tag under the hand is read each cycle so the victim's tag is ready on exit.
      S_SWEEP: begin
        ctrl_o.rd_en   = 1'b1;
        ctrl_o.rd_hand = 1'b1;
        if (stat_i.sweep_found) begin
          state_d = S_MISS;
        end else begin
          ctrl_o.sweep_step = 1'b1;
        end
      end
      S_MISS: begin
        if (stat_i.out_free) begin
          ctrl_o.emit = 1'b1;
          ctrl_o.kind = EMIT_MISS;
          state_d     = S_IDLE;
        end
      end
      // Walk down to find the highest dirty slot, which carries the last flag.
      S_FL_FIND: begin
        if (stat_i.fl_dirty) begin
          ctrl_o.lastd_load = 1'b1;
          ctrl_o.idx_op     = IDX_ZERO;
          state_d           = S_FL_CHECK;
        end else if (stat_i.idx_zero) begin
          state_d = S_FL_NONE;
        end else begin
          ctrl_o.idx_op = IDX_DEC;
        end
      end
      S_FL_NONE: begin
        if (stat_i.out_free) begin
          ctrl_o.emit = 1'b1;
          ctrl_o.kind = EMIT_NONE;
          state_d     = S_IDLE;
        end
      end
      S_FL_CHECK: begin
        if (stat_i.fl_dirty) begin
          ctrl_o.rd_en = 1'b1;
          state_d      = S_FL_OUT;
        end else begin
          ctrl_o.idx_op = IDX_INC;
        end
      end
      S_FL_OUT: begin
        if (stat_i.out_free) begin
          ctrl_o.emit = 1'b1;
          ctrl_o.kind = EMIT_FLUSH;
          if (stat_i.idx_lastd) begin
            state_d = S_IDLE;
          end else begin
            ctrl_o.idx_op = IDX_INC;
            state_d       = S_FL_CHECK;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

>>> hdl/sector_cache_clock_replacement.sv
// Channel  | Dir | Payload                                              | Transaction
// req_i    | in  | command, sector                                      | valid & ready
// rsp_o    | out | hit, slot, fill_needed, writeback_needed,            | valid & ready
//          |     | writeback_sector, last                               |
//
// Top level of the fully associative sector cache tag and policy controller with
// clock replacement. Depends on scc_pkg, scc_if, scc_controller and scc_datapath.
//
// Requests are handled one at a time. The tag store has one read port and is
// scanned one slot per cycle until a hit; a miss scans all slots, then the clock
// hand passes at most NUM_SLOTS slots. A flush walks down to the highest dirty
// slot, then walks up from slot 0 and emits one result per dirty slot.
// Reset clears valid, dirty and reference bits at once; no clearing pass.
// A new request is taken while the last result waits in the output register;
// a stalled result channel holds the controller until the register frees.
module sector_cache_clock_replacement (
  input logic     clk_i,
  input logic     rst_ni,
  scc_req_if.sink   req_i,
  scc_rsp_if.source rsp_o
);
  import scc_pkg::*;

  scc_ctrl_t ctrl;
  scc_stat_t stat;

  scc_controller u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (req_i.valid),
    .req_command_i (req_i.command),
    .req_ready_o   (req_i.ready),
    .stat_i        (stat),
    .ctrl_o        (ctrl)
  );

  scc_datapath u_dp (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .ctrl_i                 (ctrl),
    .stat_o                 (stat),
    .req_command_i          (req_i.command),
    .req_sector_i           (req_i.sector),
    .rsp_ready_i            (rsp_o.ready),
    .rsp_valid_o            (rsp_o.valid),
    .rsp_hit_o              (rsp_o.hit),
    .rsp_slot_o             (rsp_o.slot),
    .rsp_fill_needed_o      (rsp_o.fill_needed),
    .rsp_writeback_needed_o (rsp_o.writeback_needed),
    .rsp_writeback_sector_o (rsp_o.writeback_sector),
    .rsp_last_o             (rsp_o.last)
  );

endmodule

>>> bench/tb_sector_cache_clock_replacement.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sector cache tag and clock replacement controller.
// Depends on scc_pkg, the scc_req_if/scc_rsp_if interfaces and the block's RTL.
module tb_sector_cache_clock_replacement;
  import scc_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int          DRAIN_CYCLES = 2 * NUM_SLOTS + 16;
  localparam int          PRINT_LIMIT  = 30;

  typedef struct packed {
    logic    hit;
    slot_t   slot;
    logic    fill_needed;
    logic    writeback_needed;
    sector_t writeback_sector;
    logic    last;
  } cache_rsp_t;

  logic clk_i;
  logic rst_ni;

  scc_req_if req_if ();
  scc_rsp_if rsp_if ();

  sector_cache_clock_replacement u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Shadow copy of the cache directory.
  bit      line_valid [NUM_SLOTS];
  sector_t line_tag   [NUM_SLOTS];
  bit      line_dirty [NUM_SLOTS];
  bit      line_ref   [NUM_SLOTS];
  slot_t   hand;

  cache_rsp_t exp_rsp_q[$];
  sector_t    sector_pool[128];

  bit          req_idle;
  bit          rsp_idle;
  int          rsp_hold_cycles;
  int unsigned cycle_count = 0;
  int          err_count   = 0;
  int          n_items     = 0;
  int          n_ignored   = 0;
  int          n_hits      = 0;
  int          n_fills     = 0;
  int          n_evict_wb  = 0;
  int          n_flushes   = 0;
  int          n_flush_wb  = 0;
  int          n_results   = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
             exp_rsp_q.size());
    $display("status: fail");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (err_count < PRINT_LIMIT)
      $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    err_count++;
  endtask

  // Updates the shadow directory for one accepted request and queues its results.
  function automatic void predict_lookup(input logic [CMD_W-1:0] cmd, input sector_t sec);
    cache_rsp_t r;
    int         top_dirty;
    int         steps;
    bit         wb;
    r = '0;
    if (cmd == CMD_UNUSED) begin
      n_ignored++;
      return;
    end
    n_items++;
    if (cmd == CMD_FLUSH) begin
      n_flushes++;
      top_dirty = -1;
      for (int i = 0; i < NUM_SLOTS; i++)
        if (line_valid[i] && line_dirty[i]) top_dirty = i;
      if (top_dirty < 0) begin
        // Nothing dirty: a lone completion marker.
        r.last = 1'b1;
        exp_rsp_q.push_back(r);
        return;
      end
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (line_valid[i] && line_dirty[i]) begin
          r.slot             = slot_t'(i);
          r.writeback_needed = 1'b1;
          r.writeback_sector = line_tag[i];
          r.last             = (i == top_dirty);
          exp_rsp_q.push_back(r);
          line_dirty[i] = 1'b0;
          n_flush_wb++;
        end
      end
      return;
    end

    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (line_valid[i] && line_tag[i] == sec) begin
        line_ref[i] = 1'b1;
        if (cmd == CMD_WRITE) line_dirty[i] = 1'b1;
        r.hit  = 1'b1;
        r.slot = slot_t'(i);
        r.last = 1'b1;
        exp_rsp_q.push_back(r);
        n_hits++;
        return;
      end
    end

    // Second-chance sweep: stop on an empty or unreferenced slot.
    steps = 0;
    while (steps < 2 * NUM_SLOTS + 1 && line_valid[hand] && line_ref[hand]) begin
      line_ref[hand] = 1'b0;
      hand = slot_t'((int'(hand) + 1) % NUM_SLOTS);
      steps++;
    end
    wb = line_valid[hand] && line_dirty[hand];
    r.slot             = hand;
    r.fill_needed      = 1'b1;
    r.writeback_needed = wb;
    r.writeback_sector = wb ? line_tag[hand] : '0;
    r.last             = 1'b1;
    exp_rsp_q.push_back(r);
    line_valid[hand] = 1'b1;
    line_tag[hand]   = sec;
    line_dirty[hand] = (cmd == CMD_WRITE);
    line_ref[hand]   = 1'b1;
    n_fills++;
    if (wb) n_evict_wb++;
  endfunction

  // Offers one request, optionally after a random gap, and predicts it once accepted.
  task automatic send_req(input logic [CMD_W-1:0] cmd, input sector_t sec);
    int gap;
    gap = req_idle ? $urandom_range(0, 5) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.command <= cmd;
    req_if.sector  <= sec;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    predict_lookup(cmd, sec);
  endtask

  // Result sink: random stalls, plus a long hold-off when a test asks for one.
  initial begin : rsp_drive
    int gap;
    rsp_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (rsp_hold_cycles > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (rsp_hold_cycles) @(negedge clk_i);
        rsp_hold_cycles = 0;
      end
      gap = rsp_idle ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i);
      while (!(rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) && rsp_hold_cycles == 0);
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin : rsp_check
    cache_rsp_t want;
    if (rst_ni === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      n_results++;
      if (exp_rsp_q.size() == 0) begin
        report_mismatch("unexpected result, slot", 32'(rsp_if.slot), 32'hx);
      end else begin
        want = exp_rsp_q.pop_front();
        if (rsp_if.hit !== want.hit)
          report_mismatch("hit", 32'(rsp_if.hit), 32'(want.hit));
        if (rsp_if.slot !== want.slot)
          report_mismatch("slot", 32'(rsp_if.slot), 32'(want.slot));
        if (rsp_if.fill_needed !== want.fill_needed)
          report_mismatch("fill_needed", 32'(rsp_if.fill_needed), 32'(want.fill_needed));
        if (rsp_if.writeback_needed !== want.writeback_needed)
          report_mismatch("writeback_needed", 32'(rsp_if.writeback_needed),
                          32'(want.writeback_needed));
        if (rsp_if.writeback_sector !== want.writeback_sector)
          report_mismatch("writeback_sector", 32'(rsp_if.writeback_sector),
                          32'(want.writeback_sector));
        if (rsp_if.last !== want.last)
          report_mismatch("last", 32'(rsp_if.last), 32'(want.last));
      end
    end
  end

  // A flush on a cold cache must still signal completion.
  task automatic test_empty_flush();
    send_req(CMD_FLUSH, '1);
  endtask

  task automatic test_fill_and_hit();
    send_req(CMD_READ, '0);
    send_req(CMD_READ, '0);
    send_req(CMD_WRITE, '1);
    send_req(CMD_WRITE, '1);
    send_req(CMD_WRITE, 32'hAAAA_AAAA);
    send_req(CMD_READ, 32'h5555_5555);
    send_req(CMD_READ, 32'h0000_0001);
    send_req(CMD_WRITE, 32'h8000_0000);
    send_req(CMD_READ, 32'h5555_5555);
    send_req(CMD_READ, '0);
  endtask

  // Code 3 must leave the directory alone, even for a sector that is cached.
  task automatic test_unused_command();
    send_req(CMD_UNUSED, '0);
    send_req(CMD_UNUSED, 32'h1234_5678);
    send_req(CMD_READ, 32'h1234_5678);
  endtask

  task automatic test_dirty_flush();
    send_req(CMD_FLUSH, '0);
    send_req(CMD_WRITE, '0);
    send_req(CMD_FLUSH, 32'hDEAD_BEEF);
    send_req(CMD_FLUSH, '0);
  endtask

  // Results are held back long enough that the block backs up into its request port.
  task automatic test_output_backpressure();
    req_idle        = 1'b0;
    rsp_hold_cycles = 400;
    for (int i = 0; i < 12; i++)
      send_req((i % 3 == 0) ? CMD_WRITE : CMD_READ, sector_pool[$urandom_range(0, 20)]);
    req_idle = 1'b1;
  endtask

  // Reads and writes over a reusable sector set, with some flushes, stray codes
  // and fresh full-range sectors mixed in.
  task automatic test_random_traffic(input int count, input int pool_size,
                                     input bit idle_req, input bit idle_rsp);
    int          done;
    int unsigned pick;
    sector_t     sec;
    req_idle = idle_req;
    rsp_idle = idle_rsp;
    done     = 0;
    while (done < count) begin
      pick = $urandom_range(0, 99);
      sec  = (pick % 7 == 0) ? sector_t'($urandom)
                             : sector_pool[$urandom_range(0, pool_size - 1)];
      if (pick < 4) begin
        send_req(CMD_FLUSH, sector_t'($urandom));
        done++;
      end else if (pick < 6) begin
        send_req(CMD_UNUSED, sec);
      end else begin
        send_req((pick < 53) ? CMD_WRITE : CMD_READ, sec);
        done++;
      end
    end
  endtask

  initial begin : main
    rst_ni          = 1'b0;
    req_if.valid    = 1'b0;
    req_if.command  = CMD_READ;
    req_if.sector   = '0;
    req_idle        = 1'b1;
    rsp_idle        = 1'b1;
    rsp_hold_cycles = 0;
    hand            = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      line_valid[i] = 1'b0;
      line_tag[i]   = '0;
      line_dirty[i] = 1'b0;
      line_ref[i]   = 1'b0;
    end
    for (int i = 0; i < 128; i++) sector_pool[i] = sector_t'($urandom);
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_flush();
    test_fill_and_hit();
    test_unused_command();
    test_dirty_flush();
    test_output_backpressure();
    test_random_traffic(150, 48, 1'b1, 1'b1);
    test_random_traffic(150, 112, 1'b1, 1'b1);
    test_random_traffic(60, 80, 1'b0, 1'b0);
    test_random_traffic(50, 100, 1'b1, 1'b0);

    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (exp_rsp_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (exp_rsp_q.size() != 0)
      report_mismatch("leftover expected results", 32'(exp_rsp_q.size()), 32'd0);

    $display("covered %0d requests (%0d ignored codes): %0d hits, %0d fills, %0d evictions",
             n_items, n_ignored, n_hits, n_fills, n_evict_wb);
    $display("with writeback, %0d flushes writing back %0d slots; %0d results, %0d errors",
             n_flushes, n_flush_wb, n_results, err_count);
    if (err_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
